### rtl/rls_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rls_pkg: shared types and constants for the record log scanner
// Slot geometry, header codes, FNV-1a constants and the payload structs.
// ---------------------------------------------------------------------------
package rls_pkg;

    localparam int RECORD_WORDS = 22;
    localparam int MAX_SLOTS    = 2048;

    localparam int WORD_W  = 32;
    localparam int SLOT_W  = 11;
    localparam int WIS_W   = 5;
    localparam int BYTE_W  = 8;

    localparam logic [WIS_W-1:0]  WIS_LAST   = WIS_W'(RECORD_WORDS - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(MAX_SLOTS - 1);

    localparam logic [WORD_W-1:0] FNV_BASIS    = 32'h811C_9DC5;
    localparam logic [WORD_W-1:0] SLOT_MAGIC   = 32'h4346_4732;
    localparam logic [WORD_W-1:0] ERASED_WORD  = 32'hFFFF_FFFF;
    localparam logic [15:0]       SLOT_VERSION = 16'd1;
    localparam logic [15:0]       SLOT_BYTES   = 16'(RECORD_WORDS * 4);

    typedef struct packed {
        logic [WORD_W-1:0] flash_word;
        logic              area_last;
    } rls_in_t;

    typedef struct packed {
        logic              record_found;
        logic [WORD_W-1:0] best_sequence;
        logic [SLOT_W-1:0] best_slot;
        logic [WORD_W-1:0] next_sequence;
        logic [SLOT_W-1:0] free_slot;
        logic              area_full;
    } rls_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLD,
        ST_EMIT
    } rls_state_t;

    // One FNV-1a byte step: xor the byte, multiply by 0x01000193 as shifts and adds
    function automatic logic [WORD_W-1:0] fnv_byte(input logic [WORD_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] x;
        x = h ^ {24'd0, b};
        return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
    endfunction

endpackage

### rtl/record_log_scanner.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// record_log_scanner: newest valid record and first free slot of a log area
// Hashes each slot with FNV-1a one byte per cycle, checks headers and
// tracks the best sequence and the first erased slot until the area ends.
// ---------------------------------------------------------------------------
// Flow: a word that enters the hash is accepted, then folded byte by byte
// through the byte shift register with s_ready low until the folds end; a
// slot's check word and words past the slot limit take no folds. The result
// is registered once the final word is done and the output is free; one
// result may wait there while the next scan proceeds. aresetn is synchronous,
// active low; it and each result clear all scan state but the shift register.
// ---------------------------------------------------------------------------
module record_log_scanner (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rls_pkg::rls_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rls_pkg::rls_out_t m_data
);
    import rls_pkg::*;

    rls_state_t        state_reg, state_next;
    logic [WORD_W-1:0] hash_reg, hash_next;
    logic [WORD_W-1:0] shift_reg, shift_next;
    logic [1:0]        byte_cnt_reg, byte_cnt_next;
    logic              last_reg, last_next;
    logic [WIS_W-1:0]  wis_reg, wis_next;
    logic [SLOT_W-1:0] slot_idx_reg, slot_idx_next;
    logic              header_good_reg, header_good_next;
    logic              slot_erased_reg, slot_erased_next;
    logic [WORD_W-1:0] slot_seq_reg, slot_seq_next;
    logic [WORD_W-1:0] best_seq_reg, best_seq_next;
    logic [SLOT_W-1:0] best_slot_reg, best_slot_next;
    logic [SLOT_W-1:0] free_slot_reg, free_slot_next;
    logic              free_seen_reg, free_seen_next;
    logic              past_end_reg, past_end_next;
    logic              m_valid_reg, m_valid_next;
    rls_out_t          m_data_reg, m_data_next;

    logic              s_fire;
    logic              out_free;
    logic [WORD_W-1:0] w;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign w        = s_data.flash_word;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            hash_reg        <= FNV_BASIS;
            byte_cnt_reg    <= '0;
            last_reg        <= 1'b0;
            wis_reg         <= '0;
            slot_idx_reg    <= '0;
            header_good_reg <= 1'b0;
            slot_erased_reg <= 1'b0;
            slot_seq_reg    <= '0;
            best_seq_reg    <= '0;
            best_slot_reg   <= '0;
            free_slot_reg   <= '0;
            free_seen_reg   <= 1'b0;
            past_end_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            hash_reg        <= hash_next;
            byte_cnt_reg    <= byte_cnt_next;
            last_reg        <= last_next;
            wis_reg         <= wis_next;
            slot_idx_reg    <= slot_idx_next;
            header_good_reg <= header_good_next;
            slot_erased_reg <= slot_erased_next;
            slot_seq_reg    <= slot_seq_next;
            best_seq_reg    <= best_seq_next;
            best_slot_reg   <= best_slot_next;
            free_slot_reg   <= free_slot_next;
            free_seen_reg   <= free_seen_next;
            past_end_reg    <= past_end_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        shift_reg  <= shift_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next       = state_reg;
        hash_next        = hash_reg;
        shift_next       = shift_reg;
        byte_cnt_next    = byte_cnt_reg;
        last_next        = last_reg;
        wis_next         = wis_reg;
        slot_idx_next    = slot_idx_reg;
        header_good_next = header_good_reg;
        slot_erased_next = slot_erased_reg;
        slot_seq_next    = slot_seq_reg;
        best_seq_next    = best_seq_reg;
        best_slot_next   = best_slot_reg;
        free_slot_next   = free_slot_reg;
        free_seen_next   = free_seen_reg;
        past_end_next    = past_end_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    last_next  = s_data.area_last;
                    state_next = s_data.area_last ? ST_EMIT : ST_IDLE;
                    if (!past_end_reg) begin
                        if (wis_reg == WIS_W'(0)) begin
                            header_good_next = (w == SLOT_MAGIC);
                            slot_erased_next = (w == ERASED_WORD);
                        end else if (wis_reg == WIS_W'(1)) begin
                            if (w[15:0] != SLOT_VERSION || w[31:16] != SLOT_BYTES)
                                header_good_next = 1'b0;
                        end else if (wis_reg == WIS_W'(2)) begin
                            slot_seq_next = w;
                        end

                        if (wis_reg != WIS_LAST) begin
                            shift_next    = w;
                            byte_cnt_next = '0;
                            wis_next      = wis_reg + WIS_W'(1);
                            state_next    = ST_FOLD;
                        end else begin
                            // check word: close the slot
                            if (header_good_next && hash_reg == w
                                    && slot_seq_next > best_seq_reg) begin
                                best_seq_next  = slot_seq_next;
                                best_slot_next = slot_idx_reg;
                            end
                            if (slot_erased_next && !free_seen_reg) begin
                                free_seen_next = 1'b1;
                                free_slot_next = slot_idx_reg;
                            end
                            hash_next        = FNV_BASIS;
                            wis_next         = '0;
                            header_good_next = 1'b0;
                            slot_erased_next = 1'b0;
                            slot_seq_next    = '0;
                            if (slot_idx_reg == SLOT_LAST)
                                past_end_next = 1'b1;
                            else
                                slot_idx_next = slot_idx_reg + SLOT_W'(1);
                        end
                    end
                end
            end
            ST_FOLD: begin
                hash_next     = fnv_byte(hash_reg, shift_reg[BYTE_W-1:0]);
                shift_next    = shift_reg >> BYTE_W;
                byte_cnt_next = byte_cnt_reg + 2'd1;
                if (byte_cnt_reg == 2'd3)
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_data_next.record_found   = (best_seq_reg != '0);
                    m_data_next.best_sequence  = best_seq_reg;
                    m_data_next.best_slot      = best_slot_reg;
                    m_data_next.next_sequence  = best_seq_reg + WORD_W'(1);
                    m_data_next.free_slot      = free_seen_reg ? free_slot_reg : '0;
                    m_data_next.area_full      = !free_seen_reg;
                    // new scan starts from reset state
                    hash_next        = FNV_BASIS;
                    byte_cnt_next    = '0;
                    last_next        = 1'b0;
                    wis_next         = '0;
                    slot_idx_next    = '0;
                    header_good_next = 1'b0;
                    slot_erased_next = 1'b0;
                    slot_seq_next    = '0;
                    best_seq_next    = '0;
                    best_slot_next   = '0;
                    free_slot_next   = '0;
                    free_seen_next   = 1'b0;
                    past_end_next    = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    a_wis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wis_reg <= WIS_LAST)
        else $error("word_in_slot beyond slot length");

    a_byte_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_FOLD) |-> (byte_cnt_reg == 2'd0))
        else $error("byte counter not parked outside fold");

    a_past_end_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        past_end_reg |-> (slot_idx_reg == SLOT_LAST && wis_reg == '0))
        else $error("past_end set without last slot reached");

    a_free_slot_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !free_seen_reg |-> (free_slot_reg == '0))
        else $error("free slot held without erased slot seen");

    a_emit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free) |=>
            (m_valid_reg && state_reg == ST_IDLE && best_seq_reg == '0))
        else $error("result not issued or scan state not cleared");

endmodule
